[hdl/pos_pkg.sv]
// Shared types and constants for the priority-ordered slot list.
package pos_pkg;

  // Field widths fixed by the interface
  localparam int REQ_W    = 3;
  localparam int SLOT_W   = 6;
  localparam int PRIO_W   = 16;
  localparam int STATUS_W = 2;

  // Links carry one extra bit; the value 64 means "no slot"
  localparam int LINK_W = SLOT_W + 1;
  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(64);

  // Default pool size
  localparam int POOL_SLOTS_DEF = 64;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD  = 3'd0,
    REQ_DEL  = 3'd1,
    REQ_SETP = 3'd2,
    REQ_WALK = 3'd3,
    REQ_CLR  = 3'd4
  } req_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_UNUSED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

endpackage

[hdl/pos_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/priority_ordered_slot_list.sv]
// Top level: priority-sorted slot list with free-slot stack and list sequencer.
//
//  channel | direction | handshake                | word
//  in      | input     | in_valid / in_ready      | req_type, slot, priority_req
//  out     | output    | out_valid / out_ready    | status, slot_out, priority_out, last
//  cfg     | input     | cfg_wr_en (no wait)      | list_enabled
//
// One request at a time; in_ready is high only while the sequencer is idle.
// Error or pool full goes straight to the word; delete unlinks and frees the slot;
// add pops a free slot, which an empty list takes directly, else it is appended at
// the tail or inserted after a scan from the head. Walk and delete all take one entry
// per cycle. Reset is synchronous; free-stack entries carry valid bits, so no clearing
// pass. A stalled out_ready holds the walk and the final word.
module priority_ordered_slot_list #(
  parameter int POOL_SLOTS = pos_pkg::POOL_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pos_pkg::REQ_W-1:0]     in_req_type,
  input  logic [pos_pkg::SLOT_W-1:0]    in_slot,
  input  logic [pos_pkg::PRIO_W-1:0]    in_priority_req,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pos_pkg::STATUS_W-1:0]  out_status,
  output logic [pos_pkg::SLOT_W-1:0]    out_slot_out,
  output logic [pos_pkg::PRIO_W-1:0]    out_priority_out,
  output logic                          out_last,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data
);
  import pos_pkg::*;

  localparam int AW = $clog2(POOL_SLOTS);
  localparam int CW = $clog2(POOL_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_POP, S_RDS, S_LSTART, S_LTAIL, S_LSCAN,
    S_APP1, S_APP2, S_INS2, S_WALK, S_CLR, S_RESP
  } state_t;

  function automatic logic [AW-1:0] to_adr(input logic [LINK_W-1:0] l);
    return l[AW-1:0];
  endfunction

  // Registers
  state_t                 state_r, state_nxt;
  req_t                   req_r, req_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [PRIO_W-1:0]      prio_r, prio_nxt;
  logic [LINK_W-1:0]      cur_r, cur_nxt;
  logic [LINK_W-1:0]      pv_r, pv_nxt;
  logic [LINK_W-1:0]      head_r, head_nxt;
  logic [LINK_W-1:0]      tail_r, tail_nxt;
  logic [CW-1:0]          free_top_r, free_top_nxt;
  logic [POOL_SLOTS-1:0]  used_r, used_nxt;
  logic [POOL_SLOTS-1:0]  fvld_r, fvld_nxt;
  logic                   fvldq_r, fvldq_nxt;
  logic                   en_r, en_nxt;
  status_t                res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]      res_slot_r, res_slot_nxt;
  logic [PRIO_W-1:0]      res_prio_r, res_prio_nxt;
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]      out_slot_r, out_slot_nxt;
  logic [PRIO_W-1:0]      out_prio_r, out_prio_nxt;
  logic                   out_last_r, out_last_nxt;

  // RAM ports
  logic                   nx_we, nx_re, pv_we, pv_re, pr_we, pr_re, fs_we, fs_re;
  logic [AW-1:0]          nx_waddr, nx_raddr, pv_waddr, pv_raddr;
  logic [AW-1:0]          pr_waddr, pr_raddr, fs_waddr, fs_raddr;
  logic [LINK_W-1:0]      nx_wdata, nx_rd, pv_wdata, pv_rd;
  logic [PRIO_W-1:0]      pr_wdata, pr_rd;
  logic [SLOT_W-1:0]      fs_wdata, fs_rd;

  // Helpers
  logic                   out_free;
  logic [LINK_W-1:0]      s_link;
  logic [AW-1:0]          s_adr;
  logic [CW-1:0]          ftop_dec;
  logic [SLOT_W-1:0]      pop_slot;
  logic                   in_bad_slot;
  logic                   prio_gt;

  assign out_free    = !out_valid_r || out_ready;
  assign s_link      = {1'b0, slot_r};
  assign s_adr       = slot_r[AW-1:0];
  assign ftop_dec    = free_top_r - CW'(1);
  assign pop_slot    = fvldq_r ? fs_rd : SLOT_W'(free_top_r);
  assign in_bad_slot = ({1'b0, in_slot} >= LINK_W'(POOL_SLOTS)) ||
                       !used_r[in_slot[AW-1:0]];
  // shared compare unit: stored priority vs request priority
  assign prio_gt     = pr_rd > prio_r;

  // Link, priority and free-stack memories
  pos_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SLOTS)) u_next_ram (
    .clk, .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .re(nx_re), .raddr(nx_raddr), .rdata(nx_rd)
  );
  pos_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SLOTS)) u_prev_ram (
    .clk, .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .re(pv_re), .raddr(pv_raddr), .rdata(pv_rd)
  );
  pos_ram #(.WIDTH(PRIO_W), .DEPTH(POOL_SLOTS)) u_prio_ram (
    .clk, .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata),
    .re(pr_re), .raddr(pr_raddr), .rdata(pr_rd)
  );
  pos_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_SLOTS)) u_free_ram (
    .clk, .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .re(fs_re), .raddr(fs_raddr), .rdata(fs_rd)
  );

  // Sequencer next-state and memory control
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    slot_nxt       = slot_r;
    prio_nxt       = prio_r;
    cur_nxt        = cur_r;
    pv_nxt         = pv_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_top_nxt   = free_top_r;
    used_nxt       = used_r;
    fvld_nxt       = fvld_r;
    fvldq_nxt      = fvldq_r;
    en_nxt         = cfg_wr_en ? cfg_wr_data : en_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_prio_nxt   = res_prio_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_prio_nxt   = out_prio_r;
    out_last_nxt   = out_last_r;

    nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0; nx_re = 1'b0; nx_raddr = '0;
    pv_we = 1'b0; pv_waddr = '0; pv_wdata = '0; pv_re = 1'b0; pv_raddr = '0;
    pr_we = 1'b0; pr_waddr = '0; pr_wdata = '0; pr_re = 1'b0; pr_raddr = '0;
    fs_we = 1'b0; fs_waddr = '0; fs_wdata = '0; fs_re = 1'b0; fs_raddr = '0;

    unique case (state_r)
      // take a request and start its first read, or go straight to the response on an error
      S_IDLE: begin
        if (in_valid) begin
          req_nxt  = req_t'(in_req_type);
          slot_nxt = in_slot;
          prio_nxt = in_priority_req;
          unique case (req_t'(in_req_type)) inside
            REQ_ADD: begin
              if (free_top_r >= CW'(POOL_SLOTS)) begin
                res_status_nxt = ST_FULL;
                res_slot_nxt   = '0;
                res_prio_nxt   = '0;
                state_nxt      = S_RESP;
              end else begin
                fs_re     = 1'b1;
                fs_raddr  = free_top_r[AW-1:0];
                fvldq_nxt = fvld_r[free_top_r[AW-1:0]];
                state_nxt = S_POP;
              end
            end
            REQ_DEL, REQ_SETP: begin
              if (in_bad_slot) begin
                res_status_nxt = ST_UNUSED;
                res_slot_nxt   = in_slot;
                res_prio_nxt   = '0;
                state_nxt      = S_RESP;
              end else begin
                nx_re = 1'b1; nx_raddr = in_slot[AW-1:0];
                pv_re = 1'b1; pv_raddr = in_slot[AW-1:0];
                pr_re = 1'b1; pr_raddr = in_slot[AW-1:0];
                state_nxt = S_RDS;
              end
            end
            REQ_WALK: begin
              if (!en_r || head_r[SLOT_W]) begin
                res_status_nxt = ST_EMPTY;
                res_slot_nxt   = '0;
                res_prio_nxt   = '0;
                state_nxt      = S_RESP;
              end else begin
                nx_re = 1'b1; nx_raddr = to_adr(head_r);
                pr_re = 1'b1; pr_raddr = to_adr(head_r);
                cur_nxt   = head_r;
                state_nxt = S_WALK;
              end
            end
            REQ_CLR: begin
              if (head_r[SLOT_W]) begin
                res_status_nxt = ST_EMPTY;
                res_slot_nxt   = '0;
                res_prio_nxt   = '0;
                state_nxt      = S_RESP;
              end else begin
                nx_re = 1'b1; nx_raddr = to_adr(head_r);
                cur_nxt   = head_r;
                state_nxt = S_CLR;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // pop a free slot and store its priority
      S_POP: begin
        slot_nxt                    = pop_slot;
        free_top_nxt                = free_top_r + CW'(1);
        used_nxt[pop_slot[AW-1:0]]  = 1'b1;
        pr_we = 1'b1; pr_waddr = pop_slot[AW-1:0]; pr_wdata = prio_r;
        state_nxt = S_LSTART;
      end

      // unlink the target slot; delete also frees it
      S_RDS: begin
        if (!pv_rd[SLOT_W]) begin
          nx_we = 1'b1; nx_waddr = to_adr(pv_rd); nx_wdata = nx_rd;
        end else begin
          head_nxt = nx_rd;
        end
        if (!nx_rd[SLOT_W]) begin
          pv_we = 1'b1; pv_waddr = to_adr(nx_rd); pv_wdata = pv_rd;
        end else begin
          tail_nxt = pv_rd;
        end
        if (req_r == REQ_DEL) begin
          used_nxt[s_adr]               = 1'b0;
          free_top_nxt                  = ftop_dec;
          fs_we = 1'b1; fs_waddr = ftop_dec[AW-1:0]; fs_wdata = slot_r;
          fvld_nxt[ftop_dec[AW-1:0]]    = 1'b1;
          res_status_nxt = ST_OK;
          res_slot_nxt   = slot_r;
          res_prio_nxt   = pr_rd;
          state_nxt      = S_RESP;
        end else begin
          pr_we = 1'b1; pr_waddr = s_adr; pr_wdata = prio_r;
          state_nxt = S_LSTART;
        end
      end

      // empty list takes the slot directly, else check the tail
      S_LSTART: begin
        if (head_r[SLOT_W]) begin
          nx_we = 1'b1; nx_waddr = s_adr; nx_wdata = NIL_LINK;
          pv_we = 1'b1; pv_waddr = s_adr; pv_wdata = NIL_LINK;
          head_nxt       = s_link;
          tail_nxt       = s_link;
          res_status_nxt = ST_OK;
          res_slot_nxt   = slot_r;
          res_prio_nxt   = prio_r;
          state_nxt      = S_RESP;
        end else begin
          pr_re = 1'b1; pr_raddr = to_adr(tail_r);
          state_nxt = S_LTAIL;
        end
      end

      // fast append when not below the tail, else scan from head
      S_LTAIL: begin
        if (!prio_gt) begin
          state_nxt = S_APP1;
        end else begin
          nx_re = 1'b1; nx_raddr = to_adr(head_r);
          pv_re = 1'b1; pv_raddr = to_adr(head_r);
          pr_re = 1'b1; pr_raddr = to_adr(head_r);
          cur_nxt   = head_r;
          state_nxt = S_LSCAN;
        end
      end

      // one entry per cycle until a higher priority or the end of the list is found
      S_LSCAN: begin
        if (prio_gt) begin
          nx_we = 1'b1; nx_waddr = s_adr; nx_wdata = cur_r;
          pv_we = 1'b1; pv_waddr = s_adr; pv_wdata = pv_rd;
          pv_nxt    = pv_rd;
          state_nxt = S_INS2;
        end else if (nx_rd[SLOT_W]) begin
          state_nxt = S_APP1;
        end else begin
          nx_re = 1'b1; nx_raddr = to_adr(nx_rd);
          pv_re = 1'b1; pv_raddr = to_adr(nx_rd);
          pr_re = 1'b1; pr_raddr = to_adr(nx_rd);
          cur_nxt = nx_rd;
        end
      end

      // append: link tail and slot
      S_APP1: begin
        nx_we = 1'b1; nx_waddr = to_adr(tail_r); nx_wdata = s_link;
        pv_we = 1'b1; pv_waddr = s_adr; pv_wdata = tail_r;
        state_nxt = S_APP2;
      end

      S_APP2: begin
        nx_we = 1'b1; nx_waddr = s_adr; nx_wdata = NIL_LINK;
        tail_nxt       = s_link;
        res_status_nxt = ST_OK;
        res_slot_nxt   = slot_r;
        res_prio_nxt   = prio_r;
        state_nxt      = S_RESP;
      end

      // insert before cur: fix predecessor and cur
      S_INS2: begin
        if (!pv_r[SLOT_W]) begin
          nx_we = 1'b1; nx_waddr = to_adr(pv_r); nx_wdata = s_link;
        end else begin
          head_nxt = s_link;
        end
        pv_we = 1'b1; pv_waddr = to_adr(cur_r); pv_wdata = s_link;
        res_status_nxt = ST_OK;
        res_slot_nxt   = slot_r;
        res_prio_nxt   = prio_r;
        state_nxt      = S_RESP;
      end

      // walk: one word per entry, held while the output is full
      S_WALK: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_slot_nxt   = cur_r[SLOT_W-1:0];
          out_prio_nxt   = pr_rd;
          out_last_nxt   = nx_rd[SLOT_W];
          if (nx_rd[SLOT_W]) begin
            state_nxt = S_IDLE;
          end else begin
            nx_re = 1'b1; nx_raddr = to_adr(nx_rd);
            pr_re = 1'b1; pr_raddr = to_adr(nx_rd);
            cur_nxt = nx_rd;
          end
        end
      end

      // delete all: free head to tail, one slot per cycle
      S_CLR: begin
        used_nxt[to_adr(cur_r)]    = 1'b0;
        free_top_nxt               = ftop_dec;
        fs_we = 1'b1; fs_waddr = ftop_dec[AW-1:0]; fs_wdata = cur_r[SLOT_W-1:0];
        fvld_nxt[ftop_dec[AW-1:0]] = 1'b1;
        if (nx_rd[SLOT_W]) begin
          head_nxt       = NIL_LINK;
          tail_nxt       = NIL_LINK;
          res_status_nxt = ST_OK;
          res_slot_nxt   = '0;
          res_prio_nxt   = '0;
          state_nxt      = S_RESP;
        end else begin
          nx_re = 1'b1; nx_raddr = to_adr(nx_rd);
          cur_nxt = nx_rd;
        end
      end

      // hand the single final word to the output register
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_prio_nxt   = res_prio_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      req_r        <= REQ_ADD;
      slot_r       <= '0;
      prio_r       <= '0;
      cur_r        <= NIL_LINK;
      pv_r         <= NIL_LINK;
      head_r       <= NIL_LINK;
      tail_r       <= NIL_LINK;
      free_top_r   <= '0;
      used_r       <= '0;
      fvld_r       <= '0;
      fvldq_r      <= 1'b0;
      en_r         <= 1'b1;
      res_status_r <= ST_OK;
      res_slot_r   <= '0;
      res_prio_r   <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= ST_OK;
      out_slot_r   <= '0;
      out_prio_r   <= '0;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      req_r        <= req_nxt;
      slot_r       <= slot_nxt;
      prio_r       <= prio_nxt;
      cur_r        <= cur_nxt;
      pv_r         <= pv_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      free_top_r   <= free_top_nxt;
      used_r       <= used_nxt;
      fvld_r       <= fvld_nxt;
      fvldq_r      <= fvldq_nxt;
      en_r         <= en_nxt;
      res_status_r <= res_status_nxt;
      res_slot_r   <= res_slot_nxt;
      res_prio_r   <= res_prio_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
      out_prio_r   <= out_prio_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot_out     = out_slot_r;
  assign out_priority_out = out_prio_r;
  assign out_last         = out_last_r;

`ifndef SYNTH
  // stack pointer never passes the pool size
  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_top_r <= CW'(POOL_SLOTS))
    else $error("free_top beyond pool size");

  // head and tail are empty together
  a_ends_agree: assert property (@(posedge clk) disable iff (!rst_n)
    head_r[SLOT_W] == tail_r[SLOT_W])
    else $error("head and tail disagree on empty list");

  // between requests, the used count matches the stack pointer
  a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> $countones(used_r) == int'(free_top_r))
    else $error("used slots do not match free_top");

  // between requests, an empty list means no slot in use
  a_empty_pool: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> (head_r[SLOT_W] == (free_top_r == '0)))
    else $error("list emptiness does not match free_top");
`endif

endmodule
